// ===== rtl/mmtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmtf_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CMD_W     = 2;
    localparam int KEY_IN_W  = 32;
    localparam int SLOT_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef logic [KEY_WIDTH-1:0] key_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic do_add;
        logic do_remove;
        key_t key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mmtf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmtf_cell
    import mmtf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       search_en,
    input  wire logic       sel,
    input  wire logic       found_in,
    output logic            found_out,
    input  wire logic       rm_in,
    output logic            rm_out,
    input  wire key_t       prev_key,
    input  wire logic       prev_valid,
    input  wire key_t       next_key,
    input  wire logic       next_valid,
    output key_t            key_out,
    output logic            valid_out,
    output logic            first_hit
);

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic match;
    logic shift_up;

    assign match     = search_en && valid_reg && (key_reg == ctrl.key);
    assign first_hit = match && !found_in;
    assign found_out = found_in || match;

    // a removal at or before this slot pulls the next entry up
    assign shift_up  = rm_in || sel;
    assign rm_out    = shift_up;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.do_add && !found_in) begin
            key_next   = prev_key;
            valid_next = prev_valid;
        end else if (ctrl.do_remove && shift_up) begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/mru_move_to_front_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                          direction
// s_        s_cmd, s_key_value, s_slot_index               in
// m_        m_entry_valid, m_entry_key, m_add_hit,
//           m_hit_position                                 out
//
// one command is taken per cycle while s_ready is high; the row of cells compares and shifts in
// the same cycle and the result is captured in the output register.
// every cell but the last is searched; a first-match flag ripples through the row.
// reset empties the list at once; keys are not cleared.
// s_ready is low during reset and while a result is held and m_ready is low.

module mru_move_to_front_list_unit
    import mmtf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [CMD_W-1:0]    s_cmd,
    input  wire logic [KEY_IN_W-1:0] s_key_value,
    input  wire logic [SLOT_W-1:0]   s_slot_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_entry_valid,
    output logic [KEY_IN_W-1:0]      m_entry_key,
    output logic                     m_add_hit,
    output logic [SLOT_W-1:0]        m_hit_position
);

    cmd_t       cmd;
    logic       xfer;
    cell_ctrl_t ctrl;

    logic [DEPTH:0]   found;
    logic [DEPTH:0]   rm;
    key_t             cell_key   [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] sel;

    logic [IDX_W-1:0] hit_idx;
    key_t             rd_key;
    logic             rd_valid;

    logic                m_valid_reg,       m_valid_next;
    logic                entry_valid_reg,   entry_valid_next;
    logic [KEY_IN_W-1:0] entry_key_reg,     entry_key_next;
    logic                add_hit_reg,       add_hit_next;
    logic [SLOT_W-1:0]   hit_position_reg,  hit_position_next;

    assign cmd     = cmd_t'(s_cmd);
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign xfer    = s_valid && s_ready;

    assign ctrl.do_add    = xfer && (cmd == CMD_ADD);
    assign ctrl.do_remove = xfer && (cmd == CMD_REMOVE);
    assign ctrl.key       = KEY_WIDTH'(s_key_value);

    assign found[0] = 1'b0;
    assign rm[0]    = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        key_t prev_key;
        logic prev_valid;
        key_t next_key;
        logic next_valid;

        assign sel[i] = (32'(s_slot_index) == 32'(i));

        if (i == 0) begin : g_head
            assign prev_key   = ctrl.key;
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_key   = cell_key[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_key   = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_key   = cell_key[i+1];
            assign next_valid = cell_valid[i+1];
        end

        mmtf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .search_en  (i != DEPTH - 1),
            .sel        (sel[i]),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .rm_in      (rm[i]),
            .rm_out     (rm[i+1]),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .next_key   (next_key),
            .next_valid (next_valid),
            .key_out    (cell_key[i]),
            .valid_out  (cell_valid[i]),
            .first_hit  (first_hit[i])
        );
    end

    // first_hit is one-hot or zero, so an or of positions encodes it
    always_comb begin
        hit_idx  = '0;
        rd_key   = '0;
        rd_valid = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (sel[i] && cell_valid[i]) begin
                rd_key   = rd_key | cell_key[i];
                rd_valid = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg;
        entry_valid_next  = entry_valid_reg;
        entry_key_next    = entry_key_reg;
        add_hit_next      = add_hit_reg;
        hit_position_next = hit_position_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (xfer) begin
            m_valid_next      = 1'b1;
            entry_valid_next  = 1'b0;
            entry_key_next    = '0;
            add_hit_next      = 1'b0;
            hit_position_next = '0;
            case (cmd)
                CMD_ADD: begin
                    add_hit_next      = found[DEPTH];
                    hit_position_next = found[DEPTH] ? SLOT_W'(hit_idx)
                                                     : SLOT_W'(DEPTH - 1);
                end
                CMD_READ: begin
                    entry_valid_next = rd_valid;
                    entry_key_next   = KEY_IN_W'(rd_key);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_valid_reg  <= entry_valid_next;
        entry_key_reg    <= entry_key_next;
        add_hit_reg      <= add_hit_next;
        hit_position_reg <= hit_position_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_valid  = entry_valid_reg;
    assign m_entry_key    = entry_key_reg;
    assign m_add_hit      = add_hit_reg;
    assign m_hit_position = hit_position_reg;

endmodule

`default_nettype wire
